/* src/wpf_pkg.sv */
package wpf_pkg;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LIMIT    = 2'd1,
    ST_NOT_OPEN = 2'd2
  } status_t;

  localparam logic [1:0] CFG_RATE = 2'd0;
  localparam logic [1:0] CFG_CHAN = 2'd1;
  localparam logic [1:0] CFG_BITS = 2'd2;

  // byte source selected by a control word
  typedef enum logic [3:0] {
    SRC_CONST  = 4'd0,
    SRC_RIFFLEN = 4'd1,
    SRC_CHAN   = 4'd2,
    SRC_RATE   = 4'd3,
    SRC_BRATE  = 4'd4,
    SRC_ALIGN  = 4'd5,
    SRC_BITS   = 4'd6,
    SRC_DATALEN = 4'd7,
    SRC_SAMPLE = 4'd8,
    SRC_ZERO   = 4'd9
  } src_t;

  // control word: byte source, byte lane, constant, end of program
  typedef struct packed {
    src_t       src;
    logic [1:0] lane;
    logic [7:0] cval;
    logic       last;
  } uword_t;

  localparam int HdrLen = 44;
  localparam int ProgLen = 48;
  localparam logic [5:0] EntryHdr    = 6'd0;
  localparam logic [5:0] EntrySample = 6'd44;
  localparam logic [5:0] EntryReject = 6'd47;

  function automatic uword_t uw(src_t s, logic [1:0] l, logic [7:0] c, logic t);
    uword_t w;
    w.src = s; w.lane = l; w.cval = c; w.last = t;
    return w;
  endfunction

  function automatic uword_t ucode(logic [5:0] a);
    uword_t w;
    w = uw(SRC_ZERO, 2'd0, 8'h00, 1'b1);
    case (a)
      6'd0:  w = uw(SRC_CONST, 2'd0, 8'h52, 1'b0);
      6'd1:  w = uw(SRC_CONST, 2'd0, 8'h49, 1'b0);
      6'd2:  w = uw(SRC_CONST, 2'd0, 8'h46, 1'b0);
      6'd3:  w = uw(SRC_CONST, 2'd0, 8'h46, 1'b0);
      6'd4:  w = uw(SRC_RIFFLEN, 2'd0, 8'h00, 1'b0);
      6'd5:  w = uw(SRC_RIFFLEN, 2'd1, 8'h00, 1'b0);
      6'd6:  w = uw(SRC_RIFFLEN, 2'd2, 8'h00, 1'b0);
      6'd7:  w = uw(SRC_RIFFLEN, 2'd3, 8'h00, 1'b0);
      6'd8:  w = uw(SRC_CONST, 2'd0, 8'h57, 1'b0);
      6'd9:  w = uw(SRC_CONST, 2'd0, 8'h41, 1'b0);
      6'd10: w = uw(SRC_CONST, 2'd0, 8'h56, 1'b0);
      6'd11: w = uw(SRC_CONST, 2'd0, 8'h45, 1'b0);
      6'd12: w = uw(SRC_CONST, 2'd0, 8'h66, 1'b0);
      6'd13: w = uw(SRC_CONST, 2'd0, 8'h6D, 1'b0);
      6'd14: w = uw(SRC_CONST, 2'd0, 8'h74, 1'b0);
      6'd15: w = uw(SRC_CONST, 2'd0, 8'h20, 1'b0);
      6'd16: w = uw(SRC_CONST, 2'd0, 8'h10, 1'b0);
      6'd17: w = uw(SRC_CONST, 2'd0, 8'h00, 1'b0);
      6'd18: w = uw(SRC_CONST, 2'd0, 8'h00, 1'b0);
      6'd19: w = uw(SRC_CONST, 2'd0, 8'h00, 1'b0);
      6'd20: w = uw(SRC_CONST, 2'd0, 8'h01, 1'b0);
      6'd21: w = uw(SRC_CONST, 2'd0, 8'h00, 1'b0);
      6'd22: w = uw(SRC_CHAN, 2'd0, 8'h00, 1'b0);
      6'd23: w = uw(SRC_CONST, 2'd0, 8'h00, 1'b0);
      6'd24: w = uw(SRC_RATE, 2'd0, 8'h00, 1'b0);
      6'd25: w = uw(SRC_RATE, 2'd1, 8'h00, 1'b0);
      6'd26: w = uw(SRC_RATE, 2'd2, 8'h00, 1'b0);
      6'd27: w = uw(SRC_RATE, 2'd3, 8'h00, 1'b0);
      6'd28: w = uw(SRC_BRATE, 2'd0, 8'h00, 1'b0);
      6'd29: w = uw(SRC_BRATE, 2'd1, 8'h00, 1'b0);
      6'd30: w = uw(SRC_BRATE, 2'd2, 8'h00, 1'b0);
      6'd31: w = uw(SRC_BRATE, 2'd3, 8'h00, 1'b0);
      6'd32: w = uw(SRC_ALIGN, 2'd0, 8'h00, 1'b0);
      6'd33: w = uw(SRC_ALIGN, 2'd1, 8'h00, 1'b0);
      6'd34: w = uw(SRC_BITS, 2'd0, 8'h00, 1'b0);
      6'd35: w = uw(SRC_CONST, 2'd0, 8'h00, 1'b0);
      6'd36: w = uw(SRC_CONST, 2'd0, 8'h64, 1'b0);
      6'd37: w = uw(SRC_CONST, 2'd0, 8'h61, 1'b0);
      6'd38: w = uw(SRC_CONST, 2'd0, 8'h74, 1'b0);
      6'd39: w = uw(SRC_CONST, 2'd0, 8'h61, 1'b0);
      6'd40: w = uw(SRC_DATALEN, 2'd0, 8'h00, 1'b0);
      6'd41: w = uw(SRC_DATALEN, 2'd1, 8'h00, 1'b0);
      6'd42: w = uw(SRC_DATALEN, 2'd2, 8'h00, 1'b0);
      6'd43: w = uw(SRC_DATALEN, 2'd3, 8'h00, 1'b1);
      6'd44: w = uw(SRC_SAMPLE, 2'd0, 8'h00, 1'b0);
      6'd45: w = uw(SRC_SAMPLE, 2'd1, 8'h00, 1'b0);
      6'd46: w = uw(SRC_SAMPLE, 2'd2, 8'h00, 1'b1);
      6'd47: w = uw(SRC_ZERO, 2'd0, 8'h00, 1'b1);
      default: w = uw(SRC_ZERO, 2'd0, 8'h00, 1'b1);
    endcase
    return w;
  endfunction

endpackage

/* src/wpf_conv.sv */
// float to pcm24: clamp, scale by 2^23-1, round half even; two register stages
module wpf_conv (
  input  logic        clk,
  input  logic        start,
  input  logic [31:0] bits_in,
  output logic [23:0] pcm,
  output logic        done
);
  logic        neg_r, sat_r, zero_r;
  logic [23:0] man_r;
  logic [7:0]  exp_r;
  logic [23:0] pcm_r;
  logic [1:0]  vld_r;

  logic        nan;
  logic [7:0]  e;
  logic        ge1;

  assign e   = bits_in[30:23];
  assign nan = (e == 8'hFF) && (bits_in[22:0] != 23'd0);
  assign ge1 = (e >= 8'd127);

  always_ff @(posedge clk) begin
    neg_r  <= bits_in[31] | nan;
    sat_r  <= ge1 | nan;
    zero_r <= (e < 8'd103);
    man_r  <= {(e != 8'd0), bits_in[22:0]};
    exp_r  <= e;
  end

  // stage two: product m*(2^23-1) = (m<<23) - m, shifted right by 150-e
  logic [47:0] prod;
  logic [47:0] sh;
  logic [7:0]  shamt;
  logic [47:0] ulp;
  logic [47:0] half;
  logic [47:0] rem;
  logic [23:0] q, mag;
  logic        rup;

  always_comb begin
    prod  = ({24'd0, man_r} << 23) - {24'd0, man_r};
    shamt = 8'd150 - exp_r;
    if (shamt > 8'd47) shamt = 8'd47;
    sh    = prod >> shamt[5:0];
    ulp   = 48'd1 << shamt[5:0];
    half  = ulp >> 1;
    rem   = prod & (ulp - 48'd1);
    q     = sh[23:0];
    rup   = (rem > half) || ((rem == half) && q[0]);
    mag   = q + {23'd0, rup};
    if (sat_r) mag = 24'h7FFFFF;
    else if (zero_r) mag = 24'd0;
  end

  always_ff @(posedge clk) begin
    pcm_r <= neg_r ? (24'd0 - mag) : mag;
    vld_r <= {vld_r[0], start};
  end

  assign pcm  = pcm_r;
  assign done = vld_r[1];
endmodule

/* src/wav_pcm24_stream_formatter_top.sv */
// channel   | direction | signals
// in        | input     | in_valid, in_ready, in_operation, in_sample_bits
// out       | output    | out_valid, out_ready, out_out_byte, out_rewrite_at_start,
//           |           | out_last_of_run, out_status
// cfg       | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// a request is accepted in idle; a header then passes a load step and emits 44 result
// bytes, a sample waits in conversion and then emits 3 result bytes, a rejected request
// emits 1 result byte; each result byte is read from one control word
// one request at a time: in_ready is high only while the sequencer is idle
// reset (synchronous, rst_n low) closes the stream and loads default registers
// a low out_ready while a result is still held stops the sequencer on its current run step
module wav_pcm24_stream_formatter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_sample_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_byte,
  output logic        out_rewrite_at_start,
  output logic        out_last_of_run,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [19:0] rate_r;
  logic [5:0]  chan_r, hbits_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= 20'd48000;
      chan_r  <= 6'd2;
      hbits_r <= 6'd24;
    end else if (cfg_valid) begin
      case (cfg_index)
        wpf_pkg::CFG_RATE: rate_r  <= cfg_data[19:0];
        wpf_pkg::CFG_CHAN: chan_r  <= cfg_data[5:0];
        wpf_pkg::CFG_BITS: hbits_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // stream state
  logic        open_r, fail_r;
  logic [31:0] count_r;

  // sequencer
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_RUN  = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t      state_r;
  logic [5:0]  pc_r;
  logic        stream_r, rewrite_r;
  logic [1:0]  st_r;
  logic [23:0] smp_r;
  logic [15:0] align_r;
  logic [31:0] brate_r;

  logic        conv_go, conv_done;
  logic [23:0] conv_pcm;

  wpf_conv u_conv (
    .clk(clk), .start(conv_go), .bits_in(in_sample_bits),
    .pcm(conv_pcm), .done(conv_done)
  );

  logic in_fire;
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign conv_go  = in_fire && (in_operation == wpf_pkg::OP_SAMPLE) && open_r
                    && ({1'b0, count_r} + 33'd39 <= 33'hFFFFFFFF);

  // output register
  logic [7:0] byte_r;
  logic       ovld_r, olast_r, orew_r;
  logic [1:0] ost_r;

  wpf_pkg::uword_t uw;
  assign uw = wpf_pkg::ucode(pc_r);

  logic [31:0] word;
  logic [7:0]  b;
  always_comb begin
    word = 32'd0;
    case (uw.src)
      wpf_pkg::SRC_RIFFLEN: word = stream_r ? 32'hFFFFFFFF : count_r + 32'd36;
      wpf_pkg::SRC_DATALEN: word = stream_r ? 32'hFFFFFFFF : count_r;
      wpf_pkg::SRC_CHAN:    word = {26'd0, chan_r};
      wpf_pkg::SRC_RATE:    word = {12'd0, rate_r};
      wpf_pkg::SRC_BRATE:   word = brate_r;
      wpf_pkg::SRC_ALIGN:   word = {16'd0, align_r};
      wpf_pkg::SRC_BITS:    word = {26'd0, hbits_r};
      wpf_pkg::SRC_SAMPLE:  word = {8'd0, smp_r};
      wpf_pkg::SRC_CONST:   word = {24'd0, uw.cval};
      default:              word = 32'd0;
    endcase
    b = word[8*uw.lane +: 8];
  end

  logic slot_free;
  assign slot_free = !ovld_r || out_ready;

  // a result byte is loaded on every run step that finds the slot free
  logic load_out;
  assign load_out = (state_r == S_RUN) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (load_out) begin
      ovld_r <= 1'b1;
    end else if (out_ready) begin
      ovld_r <= 1'b0;
    end
  end

  logic [11:0] prod_cb;
  assign prod_cb = chan_r * hbits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      open_r  <= 1'b0;
      fail_r  <= 1'b0;
      count_r <= 32'd0;
      pc_r    <= 6'd0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          case (in_operation)
            wpf_pkg::OP_START: begin
              count_r <= 32'd0; fail_r <= 1'b0; open_r <= 1'b1;
              stream_r <= 1'b1; rewrite_r <= 1'b0; st_r <= wpf_pkg::ST_OK;
              pc_r <= wpf_pkg::EntryHdr; state_r <= S_LOAD;
            end
            wpf_pkg::OP_SAMPLE: begin
              rewrite_r <= 1'b0;
              if (!open_r) begin
                st_r <= wpf_pkg::ST_NOT_OPEN; pc_r <= wpf_pkg::EntryReject;
                state_r <= S_RUN;
              end else if (!conv_go) begin
                fail_r <= 1'b1; st_r <= wpf_pkg::ST_LIMIT;
                pc_r <= wpf_pkg::EntryReject; state_r <= S_RUN;
              end else begin
                count_r <= count_r + 32'd3;
                st_r <= fail_r ? wpf_pkg::ST_LIMIT : wpf_pkg::ST_OK;
                pc_r <= wpf_pkg::EntrySample; state_r <= S_CONV;
              end
            end
            wpf_pkg::OP_FINISH: begin
              if (!open_r) begin
                rewrite_r <= 1'b0; st_r <= wpf_pkg::ST_NOT_OPEN;
                pc_r <= wpf_pkg::EntryReject; state_r <= S_RUN;
              end else begin
                open_r <= 1'b0; stream_r <= 1'b0; rewrite_r <= 1'b1;
                st_r <= fail_r ? wpf_pkg::ST_LIMIT : wpf_pkg::ST_OK;
                pc_r <= wpf_pkg::EntryHdr; state_r <= S_LOAD;
              end
            end
            default: ;
          endcase
        end
        // derived header fields: align and byte rate
        S_LOAD: begin
          align_r <= {7'd0, prod_cb[11:3]};
          brate_r <= rate_r * {23'd0, prod_cb[11:3]};
          state_r <= S_RUN;
        end
        S_CONV: if (conv_done) begin
          smp_r <= conv_pcm; state_r <= S_RUN;
        end
        S_RUN: if (slot_free) begin
          byte_r  <= b;
          olast_r <= uw.last;
          orew_r  <= rewrite_r;
          ost_r   <= (uw.src == wpf_pkg::SRC_ZERO) ? st_r :
                     (stream_r && rewrite_r == 1'b0 && pc_r < 6'(wpf_pkg::HdrLen))
                     ? wpf_pkg::ST_OK : st_r;
          if (uw.last) state_r <= S_IDLE;
          else pc_r <= pc_r + 6'd1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = ovld_r;
  assign out_out_byte         = byte_r;
  assign out_rewrite_at_start = orew_r;
  assign out_last_of_run      = olast_r;
  assign out_status           = ost_r;

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && !out_ready |=> ovld_r && $stable(byte_r) && $stable(olast_r))
    else $error("held result changed");
  // no new request while the sequencer runs
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("ready while busy");
  // count moves in steps of three or to zero
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> count_r == 32'd0 || count_r == $past(count_r) + 32'd3)
    else $error("byte count jump");
endmodule

/* bench/wav_pcm24_stream_formatter_top_tb.sv */
`timescale 1ns / 1ps

module wav_pcm24_stream_formatter_top_tb;

  // one expected output byte with its flags
  typedef struct packed {
    logic [7:0] b;
    logic       rw;
    logic       last;
    logic [1:0] st;
  } wav_byte_t;

  // directed stimulus row; a known first byte and status are typed in where obvious
  typedef struct {
    wpf_pkg::op_t     op;
    logic [31:0]      bits;
    bit               known;
    logic [7:0]       kb;
    wpf_pkg::status_t ks;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = wpf_pkg::OP_NONE;
  logic [31:0] in_sample_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_out_byte;
  logic        out_rewrite_at_start;
  logic        out_last_of_run;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = wpf_pkg::CFG_RATE;
  logic [31:0] cfg_data = '0;

  // typed expectation riding along with the current request
  bit          req_known = 1'b0;
  logic [7:0]  req_kb = '0;
  logic [1:0]  req_ks = '0;

  // mirror of the block: registers and stream state
  logic [19:0] m_rate = 20'd48000;
  logic [5:0]  m_chan = 6'd2;
  logic [5:0]  m_bits = 6'd24;
  bit          m_open = 1'b0;
  bit          m_failed = 1'b0;
  logic [31:0] m_count = '0;

  wav_byte_t   byte_q[$];
  int          errors = 0;
  int          mismatches = 0;

  // receiver pacing
  bit          no_idle = 1'b0;
  int          hold_cnt = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stall_left = 0;

  always #2 clk = ~clk;

  wav_pcm24_stream_formatter_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_sample_bits      (in_sample_bits),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_out_byte        (out_out_byte),
    .out_rewrite_at_start(out_rewrite_at_start),
    .out_last_of_run     (out_last_of_run),
    .out_status          (out_status),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // float to 24-bit pcm: clamp to [-1,1], nan is -1, scale, round half to even
  function automatic logic [23:0] pcm24(input logic [31:0] f);
    int          e;
    int          s;
    logic [23:0] m;
    logic [47:0] p;
    logic [47:0] q;
    logic [47:0] r;
    logic [47:0] half;
    logic [23:0] mag;
    e = f[30:23];
    if (e == 255 && f[22:0] != 0) return 24'h800001;
    if (e >= 127) begin
      // at or beyond unity, infinities too
      mag = 24'd8388607;
    end else begin
      m = (e == 0) ? {1'b0, f[22:0]} : {1'b1, f[22:0]};
      if (e == 0) e = 1;
      p = m * 48'd8388607;
      s = 150 - e;
      if (s >= 48) begin
        mag = '0;
      end else begin
        q = p >> s;
        r = p & ((48'd1 << s) - 48'd1);
        half = 48'd1 << (s - 1);
        if (r > half || (r == half && q[0])) q = q + 48'd1;
        mag = q[23:0];
      end
    end
    return f[31] ? -mag : mag;
  endfunction

  // append one expected byte
  task automatic put_byte(input wav_byte_t w);
    byte_q.insert(byte_q.size(), w);
  endtask

  // queue the 44 header bytes, streaming or with the real lengths
  task automatic queue_header(input bit streaming, input bit rw, input logic [1:0] st);
    logic [7:0]  h[44];
    logic [31:0] align;
    logic [31:0] brate;
    logic [31:0] rate32;
    logic [31:0] riff_len;
    logic [31:0] data_len;
    wav_byte_t   w;
    align = ((32'(m_chan) * 32'(m_bits)) / 32'd8) & 32'hFFFF;
    rate32 = {12'd0, m_rate};
    brate = rate32 * align;
    riff_len = streaming ? 32'hFFFFFFFF : 32'd36 + m_count;
    data_len = streaming ? 32'hFFFFFFFF : m_count;
    h[0] = "R"; h[1] = "I"; h[2] = "F"; h[3] = "F";
    for (int i = 0; i < 4; i++) h[4 + i] = riff_len[8*i +: 8];
    h[8] = "W"; h[9] = "A"; h[10] = "V"; h[11] = "E";
    h[12] = "f"; h[13] = "m"; h[14] = "t"; h[15] = " ";
    h[16] = 8'h10; h[17] = 8'h00; h[18] = 8'h00; h[19] = 8'h00;
    h[20] = 8'h01; h[21] = 8'h00;
    h[22] = {2'b00, m_chan}; h[23] = 8'h00;
    for (int i = 0; i < 4; i++) h[24 + i] = rate32[8*i +: 8];
    for (int i = 0; i < 4; i++) h[28 + i] = brate[8*i +: 8];
    h[32] = align[7:0]; h[33] = align[15:8];
    h[34] = {2'b00, m_bits}; h[35] = 8'h00;
    h[36] = "d"; h[37] = "a"; h[38] = "t"; h[39] = "a";
    for (int i = 0; i < 4; i++) h[40 + i] = data_len[8*i +: 8];
    for (int i = 0; i < 44; i++) begin
      w = '{b: h[i], rw: rw, last: 1'b0, st: st};
      put_byte(w);
    end
  endtask

  // expected bytes for one accepted request
  task automatic predict_request(input logic [1:0] op, input logic [31:0] bits,
                                 input bit known, input logic [7:0] kb,
                                 input logic [1:0] ks);
    int          first;
    logic [23:0] s;
    logic [1:0]  st;
    first = byte_q.size();
    case (op)
      wpf_pkg::OP_START: begin
        m_count = '0;
        m_failed = 1'b0;
        m_open = 1'b1;
        queue_header(1'b1, 1'b0, wpf_pkg::ST_OK);
      end
      wpf_pkg::OP_SAMPLE: begin
        if (!m_open) begin
          put_byte('{b: 8'h00, rw: 1'b0, last: 1'b0, st: wpf_pkg::ST_NOT_OPEN});
        end else if ({32'd0, m_count} + 64'd39 > 64'hFFFFFFFF) begin
          // length limit: sample dropped, failure sticks until the next start
          m_failed = 1'b1;
          put_byte('{b: 8'h00, rw: 1'b0, last: 1'b0, st: wpf_pkg::ST_LIMIT});
        end else begin
          s = pcm24(bits);
          st = m_failed ? wpf_pkg::ST_LIMIT : wpf_pkg::ST_OK;
          m_count = m_count + 32'd3;
          put_byte('{b: s[7:0], rw: 1'b0, last: 1'b0, st: st});
          put_byte('{b: s[15:8], rw: 1'b0, last: 1'b0, st: st});
          put_byte('{b: s[23:16], rw: 1'b0, last: 1'b0, st: st});
        end
      end
      wpf_pkg::OP_FINISH: begin
        if (!m_open) begin
          put_byte('{b: 8'h00, rw: 1'b0, last: 1'b0, st: wpf_pkg::ST_NOT_OPEN});
        end else begin
          queue_header(1'b0, 1'b1, m_failed ? wpf_pkg::ST_LIMIT : wpf_pkg::ST_OK);
          m_open = 1'b0;
        end
      end
      default: return;  // unused code is ignored
    endcase
    byte_q[byte_q.size() - 1].last = 1'b1;
    if (known) begin
      byte_q[first].b = kb;
      byte_q[first].st = ks;
    end
  endtask

  // scoreboard: compare outputs, track register writes, predict requests
  always @(posedge clk) begin
    wav_byte_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (byte_q.size() == 0) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output byte %h status %0d", out_out_byte, out_status);
        end else begin
          e = byte_q.pop_front();
          if (out_out_byte !== e.b || out_rewrite_at_start !== e.rw ||
              out_last_of_run !== e.last || out_status !== e.st) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp byte %h rw %b last %b st %0d, got %h %b %b %0d",
                       e.b, e.rw, e.last, e.st, out_out_byte, out_rewrite_at_start,
                       out_last_of_run, out_status);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wpf_pkg::CFG_RATE: m_rate = cfg_data[19:0];
          wpf_pkg::CFG_CHAN: m_chan = cfg_data[5:0];
          wpf_pkg::CFG_BITS: m_bits = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_request(in_operation, in_sample_bits, req_known, req_kb, req_ks);
    end
  end

  // receiver: random stall after some bytes, plus a long hold-off when hold_cnt moves
  always @(posedge clk) begin
    int d;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cnt != hold_seen) begin
      hold_seen <= hold_cnt;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      d = 0;
      if (out_valid && out_ready && !no_idle && $urandom_range(0, 2) != 0)
        d = $urandom_range(0, 16);
      stall_left <= d;
      out_ready <= (d == 0);
    end
  end

  // one request; valid only drops when a gap is drawn
  task automatic send_request(input logic [1:0] op, input logic [31:0] bits,
                              input bit known = 1'b0, input logic [7:0] kb = '0,
                              input logic [1:0] ks = wpf_pkg::ST_OK);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_sample_bits <= bits;
    req_known <= known;
    req_kb <= kb;
    req_ks <= ks;
    do @(posedge clk); while (!in_ready);
  endtask

  // called in the step of the last accept: stop offering and let everything drain
  task automatic drain_stream();
    in_valid <= 1'b0;
    @(posedge clk);
    while (byte_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sample values: about half near range, some anything, some special encodings
  function automatic logic [31:0] pick_sample();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1, 2, 3: v = {1'($urandom_range(0, 1)), 8'($urandom_range(100, 127)),
                    23'($urandom)};
      default: begin
        case ($urandom_range(0, 7))
          0: v = 32'h3F800000;
          1: v = 32'hBF800000;
          2: v = {1'($urandom_range(0, 1)), 8'hFF, 23'd0};
          3: v = {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom) | 23'd1};
          4: v = {1'($urandom_range(0, 1)), 8'h00, 23'($urandom)};
          5: v = {1'($urandom_range(0, 1)), 8'd126, 23'd0};
          6: v = {1'($urandom_range(0, 1)), 8'($urandom_range(128, 254)), 23'($urandom)};
          default: v = {1'($urandom_range(0, 1)), 31'd0};
        endcase
      end
    endcase
    return v;
  endfunction

  // random traffic: mostly whole streams, the rest noise and broken streams
  task automatic random_traffic(input int target);
    int sent;
    int n;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 9) < 7) begin
        send_request(wpf_pkg::OP_START, $urandom);
        n = $urandom_range(0, 12);
        for (int i = 0; i < n; i++) send_request(wpf_pkg::OP_SAMPLE, pick_sample());
        // sometimes leave the stream open, restarted by the next start
        if ($urandom_range(0, 5) != 0) send_request(wpf_pkg::OP_FINISH, $urandom);
        sent += n + 2;
      end else begin
        case ($urandom_range(0, 3))
          0: send_request(wpf_pkg::OP_NONE, $urandom);
          1: send_request(wpf_pkg::OP_SAMPLE, pick_sample());
          2: send_request(wpf_pkg::OP_FINISH, $urandom);
          default: send_request(2'($urandom_range(0, 3)), $urandom);
        endcase
        sent++;
      end
    end
  endtask

  dir_row_t dir_rows[] = '{
    '{wpf_pkg::OP_SAMPLE, 32'h3F800000, 1'b1, 8'h00, wpf_pkg::ST_NOT_OPEN},  // closed
    '{wpf_pkg::OP_FINISH, 32'h00000000, 1'b1, 8'h00, wpf_pkg::ST_NOT_OPEN},  // closed
    '{wpf_pkg::OP_NONE,   32'hFFFFFFFF, 1'b0, 8'h00, wpf_pkg::ST_OK},  // unused code
    '{wpf_pkg::OP_START,  32'h00000000, 1'b1, 8'h52, wpf_pkg::ST_OK},
    '{wpf_pkg::OP_SAMPLE, 32'h3F800000, 1'b1, 8'hFF, wpf_pkg::ST_OK},  // +1.0
    '{wpf_pkg::OP_SAMPLE, 32'hBF800000, 1'b1, 8'h01, wpf_pkg::ST_OK},  // -1.0
    '{wpf_pkg::OP_SAMPLE, 32'h7FC00000, 1'b1, 8'h01, wpf_pkg::ST_OK},  // nan is -1
    '{wpf_pkg::OP_SAMPLE, 32'hFFFFFFFF, 1'b1, 8'h01, wpf_pkg::ST_OK},  // negative nan
    '{wpf_pkg::OP_SAMPLE, 32'h7F800000, 1'b1, 8'hFF, wpf_pkg::ST_OK},  // +inf clamps
    '{wpf_pkg::OP_SAMPLE, 32'hFF800000, 1'b1, 8'h01, wpf_pkg::ST_OK},  // -inf clamps
    '{wpf_pkg::OP_SAMPLE, 32'h7F7FFFFF, 1'b1, 8'hFF, wpf_pkg::ST_OK},  // largest finite
    '{wpf_pkg::OP_SAMPLE, 32'h00000000, 1'b1, 8'h00, wpf_pkg::ST_OK},
    '{wpf_pkg::OP_SAMPLE, 32'h80000000, 1'b1, 8'h00, wpf_pkg::ST_OK},  // negative zero
    '{wpf_pkg::OP_SAMPLE, 32'h00000001, 1'b0, 8'h00, wpf_pkg::ST_OK},  // denormal
    '{wpf_pkg::OP_SAMPLE, 32'h3F000000, 1'b0, 8'h00, wpf_pkg::ST_OK},  // 0.5, tie
    '{wpf_pkg::OP_SAMPLE, 32'hBF000000, 1'b0, 8'h00, wpf_pkg::ST_OK},
    '{wpf_pkg::OP_SAMPLE, 32'h3EFFFFFF, 1'b0, 8'h00, wpf_pkg::ST_OK},
    '{wpf_pkg::OP_SAMPLE, 32'h33800000, 1'b0, 8'h00, wpf_pkg::ST_OK},
    '{wpf_pkg::OP_START,  32'hFFFFFFFF, 1'b1, 8'h52, wpf_pkg::ST_OK},  // restart
    '{wpf_pkg::OP_SAMPLE, 32'h3F400000, 1'b0, 8'h00, wpf_pkg::ST_OK},
    '{wpf_pkg::OP_FINISH, 32'hFFFFFFFF, 1'b1, 8'h52, wpf_pkg::ST_OK},
    '{wpf_pkg::OP_FINISH, 32'h00000000, 1'b1, 8'h00, wpf_pkg::ST_NOT_OPEN},  // again
    '{wpf_pkg::OP_START,  32'h00000000, 1'b1, 8'h52, wpf_pkg::ST_OK},
    '{wpf_pkg::OP_FINISH, 32'h00000000, 1'b1, 8'h52, wpf_pkg::ST_OK}   // empty stream
  };

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset register values
    foreach (dir_rows[i])
      send_request(dir_rows[i].op, dir_rows[i].bits, dir_rows[i].known,
                   dir_rows[i].kb, dir_rows[i].ks);
    drain_stream();

    // smallest register values
    write_reg(wpf_pkg::CFG_RATE, 32'd1);
    write_reg(wpf_pkg::CFG_CHAN, 32'd1);
    write_reg(wpf_pkg::CFG_BITS, 32'd8);
    random_traffic(50);
    drain_stream();

    // largest legal values, receiver held off while the sender keeps offering
    write_reg(wpf_pkg::CFG_RATE, 32'd768000);
    write_reg(wpf_pkg::CFG_CHAN, 32'd32);
    write_reg(wpf_pkg::CFG_BITS, 32'd32);
    hold_cnt <= hold_cnt + 1;
    random_traffic(50);
    drain_stream();

    // all ones, masked to the register widths; no idling on either side
    write_reg(wpf_pkg::CFG_RATE, 32'hFFFFFFFF);
    write_reg(wpf_pkg::CFG_CHAN, 32'hFFFFFFFF);
    write_reg(wpf_pkg::CFG_BITS, 32'hFFFFFFFF);
    no_idle <= 1'b1;
    random_traffic(50);
    drain_stream();
    no_idle <= 1'b0;

    // a couple of random settings
    for (int p = 0; p < 2; p++) begin
      write_reg(wpf_pkg::CFG_RATE, $urandom);
      write_reg(wpf_pkg::CFG_CHAN, 32'($urandom_range(1, 32)));
      write_reg(wpf_pkg::CFG_BITS, 32'($urandom_range(8, 32)));
      random_traffic(50);
      drain_stream();
    end

    if (errors == 0 && byte_q.size() == 0) begin
      $display("wav_pcm24_stream_formatter_top_tb passed");
    end else begin
      $display("wav_pcm24_stream_formatter_top_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("wav_pcm24_stream_formatter_top_tb failed");
    $finish;
  end

endmodule

/* sim.f */
src/wpf_pkg.sv
src/wpf_conv.sv
src/wav_pcm24_stream_formatter_top.sv
bench/wav_pcm24_stream_formatter_top_tb.sv
